// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GVBL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define GVBL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/gvbl_pkg.sv =====
// ----------------------------------------------------------------------------
// GC victim bucket lists package
// Sizes, codes, controller commands and shared index helpers.
// ----------------------------------------------------------------------------
package gvbl_pkg;

  localparam int DIES            = 8;
  localparam int BLOCKS_PER_DIE  = 1024;
  localparam int PAGES_PER_BLOCK = 128;
  localparam int NB              = PAGES_PER_BLOCK + 1;

  localparam int ACT_W  = 3;
  localparam int DIE_W  = 3;
  localparam int BLK_W  = 10;
  localparam int CNT_W  = 8;
  localparam int LINK_W = $clog2(BLOCKS_PER_DIE + 1);
  localparam int BKT_W  = $clog2(NB);
  localparam int QIDX_W = $clog2(DIES * NB);
  localparam int BIDX_W = $clog2(DIES * BLOCKS_PER_DIE);

  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(BLOCKS_PER_DIE);
  localparam logic [BKT_W-1:0]  TOP_BKT   = BKT_W'(PAGES_PER_BLOCK);

  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PEEK   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PICK   = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_SCAN, S_CHK, S_RDHEAD, S_HEAD, S_POP,
    S_TAIL, S_INS_A, S_INS_B, S_LINKS, S_REM, S_OUT, S_CLR
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_DEC, CMD_SCAN, CMD_RD_HEAD, CMD_HEAD, CMD_POP,
    CMD_RD_TAIL, CMD_INS_A, CMD_INS_B, CMD_RD_LINKS, CMD_REM, CMD_OUT, CMD_CLR
  } cmd_e;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             req_ok;
    logic             scan_last;
    logic             found;
    logic             out_free;
    logic             clr_last;
  } dp_sts_t;

  function automatic logic [QIDX_W-1:0] qidx(input logic [DIE_W-1:0] d,
                                             input logic [BKT_W-1:0] q);
    return QIDX_W'(32'(d) * NB + 32'(q));
  endfunction

  function automatic logic [BIDX_W-1:0] bidx(input logic [DIE_W-1:0] d,
                                             input logic [BLK_W-1:0] b);
    return BIDX_W'(32'(d) * BLOCKS_PER_DIE + 32'(b));
  endfunction

endpackage

// ===== src/gvbl_req_if.sv =====
// ----------------------------------------------------------------------------
// GC victim request channel
// Valid/ready channel carrying one table action per beat.
// ----------------------------------------------------------------------------
interface gvbl_req_if import gvbl_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [DIE_W-1:0] die;
  logic [BLK_W-1:0] block;
  logic [CNT_W-1:0] invalid_count;

  modport source (output valid, action, die, block, invalid_count, input ready);
  modport sink   (input valid, action, die, block, invalid_count, output ready);
endinterface

// ===== src/gvbl_rsp_if.sv =====
// ----------------------------------------------------------------------------
// GC victim response channel
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface gvbl_rsp_if import gvbl_pkg::*;;
  logic             valid;
  logic             ready;
  logic             status;
  logic [DIE_W-1:0] out_die;
  logic [BLK_W-1:0] out_block;

  modport source (output valid, status, out_die, out_block, input ready);
  modport sink   (input valid, status, out_die, out_block, output ready);
endinterface

// ===== src/gvbl_dp.sv =====
// ----------------------------------------------------------------------------
// GC victim datapath
// Bucket head/tail and block link memories, bucket occupancy maps, the
// per-die bucket scan and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gvbl_dp import gvbl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_e             cmd_i,
  output dp_sts_t          sts_o,
  input  logic             req_valid_i,
  input  logic [ACT_W-1:0] action_i,
  input  logic [DIE_W-1:0] die_i,
  input  logic [BLK_W-1:0] block_i,
  input  logic [CNT_W-1:0] count_i,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  output logic             status_o,
  output logic [DIE_W-1:0] out_die_o,
  output logic [BLK_W-1:0] out_block_o
);

  logic [ACT_W-1:0] act_q;
  logic [DIE_W-1:0] die_q, bd_q, sd_q;
  logic [BLK_W-1:0] blk_q, rb_q;
  logic [CNT_W-1:0] cnt_q;
  logic [BKT_W-1:0] bq_q;
  logic             st_q;
  logic             ov_q, ost_q;
  logic [DIE_W-1:0] odie_q;
  logic [BLK_W-1:0] oblk_q;
  logic [QIDX_W-1:0] clr_q;

  logic [NB-1:0] hv_q [DIES];

  logic [BLK_W-1:0]  head_mem [DIES*NB];
  logic [LINK_W-1:0] tail_mem [DIES*NB];
  logic [LINK_W-1:0] next_mem [DIES*BLOCKS_PER_DIE];
  logic [LINK_W-1:0] prev_mem [DIES*BLOCKS_PER_DIE];
  logic [BKT_W-1:0]  bkt_mem  [DIES*BLOCKS_PER_DIE];

  logic [BLK_W-1:0]  head_rd_q;
  logic [LINK_W-1:0] tail_rd_q;
  logic [LINK_W-1:0] next_rd_q, prev_rd_q;
  logic [BKT_W-1:0]  bkt_rd_q;

  logic              head_we, head_re, tail_we, tail_re;
  logic              next_we, next_re, prev_we, bkt_we, bkt_re;
  logic [BLK_W-1:0]  head_wd;
  logic [LINK_W-1:0] tail_wd;
  logic [LINK_W-1:0] next_wd, prev_wd;
  logic [BIDX_W-1:0] next_wa, next_ra, prev_wa, own_bi;
  logic              hv_set, hv_clr;
  logic [DIE_W-1:0]  kd;
  logic [BKT_W-1:0]  kb, qclamp, top;
  logic [QIDX_W-1:0] k;
  logic              nx_v, pv_v, tvw, req_ok;

  function automatic logic [BKT_W-1:0] top_of(input logic [NB-1:0] v);
    logic [BKT_W-1:0] r;
    r = '0;
    for (int i = 1; i < NB; i++) begin
      if (v[i]) r = BKT_W'(i);
    end
    return r;
  endfunction

  assign top    = top_of(hv_q[sd_q]);
  assign qclamp = (bkt_rd_q > TOP_BKT) ? TOP_BKT : bkt_rd_q;
  assign own_bi = bidx(die_q, blk_q);
  assign k      = (cmd_i == CMD_CLR) ? clr_q : qidx(kd, kb);

  always_comb begin
    req_ok = 1'b0;
    if (32'(die_q) < DIES) begin
      unique case (act_q)
        ACT_INSERT: req_ok = (32'(blk_q) < BLOCKS_PER_DIE) &&
                             (32'(cnt_q) <= PAGES_PER_BLOCK);
        ACT_REMOVE: req_ok = (32'(blk_q) < BLOCKS_PER_DIE);
        ACT_PEEK, ACT_POP: req_ok = 1'b1;
        default: req_ok = 1'b0;
      endcase
    end
  end

  assign sts_o.act       = act_q;
  assign sts_o.req_ok    = req_ok;
  assign sts_o.scan_last = (act_q == ACT_PICK) ? (32'(sd_q) == DIES - 1) : 1'b1;
  assign sts_o.found     = (bq_q != '0);
  assign sts_o.out_free  = !ov_q || rsp_ready_i;
  assign sts_o.clr_last  = (32'(clr_q) == DIES * NB - 1);

  always_comb begin
    kd = die_q;
    kb = BKT_W'(cnt_q);
    if (cmd_i == CMD_REM) begin
      kb = qclamp;
    end else if (cmd_i == CMD_RD_HEAD || cmd_i == CMD_POP) begin
      kd = bd_q;
      kb = bq_q;
    end
  end

  assign nx_v = next_rd_q < LINK_NONE;
  assign pv_v = prev_rd_q < LINK_NONE;
  assign tvw  = tail_rd_q < LINK_NONE;

  always_comb begin
    head_we = 1'b0; head_re = 1'b0; head_wd = blk_q;
    tail_we = 1'b0; tail_re = 1'b0; tail_wd = LINK_W'(blk_q);
    next_we = 1'b0; next_re = 1'b0; next_wd = LINK_NONE; next_wa = own_bi;
    next_ra = own_bi;
    prev_we = 1'b0; prev_wd = LINK_NONE; prev_wa = own_bi;
    bkt_we  = 1'b0; bkt_re  = 1'b0;
    hv_set  = 1'b0; hv_clr  = 1'b0;
    case (cmd_i)
      CMD_CLR: begin
        tail_we = 1'b1;
        tail_wd = LINK_NONE;
      end
      CMD_RD_TAIL: tail_re = 1'b1;
      CMD_INS_A: begin
        bkt_we  = 1'b1;
        next_we = 1'b1;
        prev_we = 1'b1;
        prev_wd = tvw ? tail_rd_q : LINK_NONE;
        tail_we = 1'b1;
        if (!tvw) begin
          head_we = 1'b1;
          hv_set  = 1'b1;
        end
      end
      CMD_INS_B: begin
        next_we = tvw;
        next_wa = bidx(die_q, tail_rd_q[BLK_W-1:0]);
        next_wd = LINK_W'(blk_q);
      end
      CMD_RD_LINKS: begin
        next_re = 1'b1;
        bkt_re  = 1'b1;
      end
      CMD_REM: begin
        next_wa = bidx(die_q, prev_rd_q[BLK_W-1:0]);
        prev_wa = bidx(die_q, next_rd_q[BLK_W-1:0]);
        if (nx_v && pv_v) begin
          next_we = 1'b1; next_wd = next_rd_q;
          prev_we = 1'b1; prev_wd = prev_rd_q;
        end else if (pv_v) begin
          next_we = 1'b1;
          tail_we = 1'b1; tail_wd = prev_rd_q;
        end else if (nx_v) begin
          prev_we = 1'b1;
          head_we = 1'b1; head_wd = next_rd_q[BLK_W-1:0];
          hv_set  = 1'b1;
        end else begin
          hv_clr  = 1'b1;
          tail_we = 1'b1; tail_wd = LINK_NONE;
        end
      end
      CMD_RD_HEAD: head_re = 1'b1;
      CMD_HEAD: begin
        next_re = (act_q == ACT_POP);
        next_ra = bidx(bd_q, head_rd_q);
      end
      CMD_POP: begin
        prev_wa = bidx(bd_q, next_rd_q[BLK_W-1:0]);
        if (nx_v) begin
          prev_we = 1'b1;
          head_we = 1'b1; head_wd = next_rd_q[BLK_W-1:0];
        end else begin
          hv_clr  = 1'b1;
          tail_we = 1'b1; tail_wd = LINK_NONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[k] <= head_wd;
    if (head_re) head_rd_q <= head_mem[k];
    if (tail_we) tail_mem[k] <= tail_wd;
    if (tail_re) tail_rd_q <= tail_mem[k];
    if (next_we) next_mem[next_wa] <= next_wd;
    if (next_re) next_rd_q <= next_mem[next_ra];
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (next_re && cmd_i == CMD_RD_LINKS) prev_rd_q <= prev_mem[own_bi];
    if (bkt_we) bkt_mem[own_bi] <= BKT_W'(cnt_q);
    if (bkt_re) bkt_rd_q <= bkt_mem[own_bi];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < DIES; d++) begin
        hv_q[d] <= '0;
      end
    end else begin
      if (hv_set) hv_q[kd][kb] <= 1'b1;
      if (hv_clr) hv_q[kd][kb] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i == CMD_CLR) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        if (req_valid_i) begin
          act_q <= action_i;
          die_q <= die_i;
          blk_q <= block_i;
          cnt_q <= count_i;
        end
      end
      CMD_DEC: begin
        st_q <= !(req_ok && (act_q == ACT_INSERT || act_q == ACT_REMOVE));
        rb_q <= '0;
        bq_q <= '0;
        bd_q <= (act_q == ACT_PICK) ? '0 : die_q;
        sd_q <= (act_q == ACT_PICK) ? '0 : die_q;
      end
      CMD_SCAN: begin
        if (top > bq_q) begin
          bq_q <= top;
          bd_q <= sd_q;
        end
        sd_q <= sd_q + 1'b1;
      end
      CMD_RD_HEAD: st_q <= 1'b0;
      CMD_HEAD:    rb_q <= head_rd_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i == CMD_OUT) begin
      ov_q <= 1'b1;
    end else if (rsp_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_OUT) begin
      ost_q  <= st_q;
      odie_q <= bd_q;
      oblk_q <= rb_q;
    end
  end

  assign rsp_valid_o = ov_q;
  assign status_o    = ost_q;
  assign out_die_o   = odie_q;
  assign out_block_o = oblk_q;

  `GVBL_ASSERT_IMP(a_head_live, cmd_i == CMD_RD_HEAD, bq_q != '0 && hv_q[bd_q][bq_q])
  `GVBL_ASSERT_NEXT(a_out_loaded, cmd_i == CMD_OUT, ov_q)

endmodule

// ===== src/gvbl_ctrl.sv =====
// ----------------------------------------------------------------------------
// GC victim controller
// Sequences memory reads, relinks, bucket scans and the result beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gvbl_ctrl import gvbl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output cmd_e    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLR;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = CMD_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLR: begin
        cmd_o = CMD_CLR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o      = CMD_LOAD;
        if (in_valid_i) state_d = S_DEC;
      end
      S_DEC: begin
        cmd_o = CMD_DEC;
        if (sts_i.act == ACT_PICK) state_d = S_SCAN;
        else if (!sts_i.req_ok) state_d = S_OUT;
        else if (sts_i.act == ACT_INSERT) state_d = S_TAIL;
        else if (sts_i.act == ACT_REMOVE) state_d = S_LINKS;
        else state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o = CMD_SCAN;
        if (sts_i.scan_last) state_d = S_CHK;
      end
      S_CHK:    state_d = sts_i.found ? S_RDHEAD : S_OUT;
      S_RDHEAD: begin
        cmd_o   = CMD_RD_HEAD;
        state_d = S_HEAD;
      end
      S_HEAD: begin
        cmd_o   = CMD_HEAD;
        state_d = (sts_i.act == ACT_POP) ? S_POP : S_OUT;
      end
      S_POP: begin
        cmd_o   = CMD_POP;
        state_d = S_OUT;
      end
      S_TAIL: begin
        cmd_o   = CMD_RD_TAIL;
        state_d = S_INS_A;
      end
      S_INS_A: begin
        cmd_o   = CMD_INS_A;
        state_d = S_INS_B;
      end
      S_INS_B: begin
        cmd_o   = CMD_INS_B;
        state_d = S_OUT;
      end
      S_LINKS: begin
        cmd_o   = CMD_RD_LINKS;
        state_d = S_REM;
      end
      S_REM: begin
        cmd_o   = CMD_REM;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o   = CMD_OUT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `GVBL_ASSERT_NEXT(a_accept_dec, in_valid_i && in_ready_o, state_q == S_DEC)
  `GVBL_ASSERT_IMP(a_out_free, cmd_o == CMD_OUT, sts_i.out_free)

endmodule

// ===== src/gc_victim_bucket_lists_core.sv =====
// Accept to result valid follows the controller: insert reads the tail, then links in;
// remove reads the links, then unlinks; peek, pop and pick scan the die (pick every die)
// and read the head, pop also unlinks it; empty lookups and rejected requests skip to the result.
// One action in flight; the next beat is taken once the result is loaded
// into the output register, which waits out any stall on the result channel.
// Reset: occupancy maps clear at once, then a clearing pass over every tail entry, ready low.
// ----------------------------------------------------------------------------
// GC victim bucket lists core
// Per-die FIFO bucket lists by invalid-page count with victim selection.
// ----------------------------------------------------------------------------
module gc_victim_bucket_lists_core import gvbl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  gvbl_req_if.sink    req_i,
  gvbl_rsp_if.source  rsp_o
);

  cmd_e    cmd;
  dp_sts_t sts;
  logic    ready;

  assign req_i.ready = ready;

  gvbl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gvbl_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_valid_i (req_i.valid),
    .action_i    (req_i.action),
    .die_i       (req_i.die),
    .block_i     (req_i.block),
    .count_i     (req_i.invalid_count),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .status_o    (rsp_o.status),
    .out_die_o   (rsp_o.out_die),
    .out_block_o (rsp_o.out_block)
  );

endmodule
